[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Check that expr never holds outside of reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

[sv/ssq_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssq_pkg
// Types and constants of the stable sorted priority queue.
// ---------------------------------------------------------------------------
package ssq_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned ElemW  = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned CountW = 5;

  typedef enum logic [OpW-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_STAT = 2'd2
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    op_e  op;
    logic reject;
  } ssq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
  } ssq_status_t;

endpackage

[sv/stable_sorted_priority_queue.sv]
`timescale 1ns / 1ps
// A result beat is valid in the cycle after its input beat is accepted.
// Throughput: one item per cycle while the output side takes each beat; the
// insert or remove is a single parallel compare-and-shift over the
// DEPTH cells. Reset clears the entry count and the output valid; the
// cells themselves are not cleared and are only read below the count.
// ---------------------------------------------------------------------------
// stable_sorted_priority_queue
// Sorted priority queue, FIFO order among equal priorities, one status
// result per item.
// ---------------------------------------------------------------------------
module stable_sorted_priority_queue import ssq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OpW-1:0]    op_i,
  input  logic [ElemW-1:0]  elem_i,
  input  logic [PrioW-1:0]  priority_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ElemW-1:0]  front_elem_o,
  output logic [PrioW-1:0]  front_priority_o,
  output logic [CountW-1:0] count_o,
  output logic              empty_res_o,
  output logic              rejected_o
);

  ssq_cmd_t    cmd;
  ssq_status_t status;

  ssq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ssq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .elem_i           (elem_i),
    .prio_i           (priority_req_i),
    .front_elem_o     (front_elem_o),
    .front_priority_o (front_priority_o),
    .count_o          (count_o),
    .empty_res_o      (empty_res_o),
    .rejected_o       (rejected_o)
  );

endmodule

[sv/ssq_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssq_datapath
// Chain of compare-and-shift cells holding the sorted entries, the entry
// count and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssq_datapath import ssq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssq_cmd_t          cmd_i,
  output ssq_status_t       status_o,
  input  logic [ElemW-1:0]  elem_i,
  input  logic [PrioW-1:0]  prio_i,
  output logic [ElemW-1:0]  front_elem_o,
  output logic [PrioW-1:0]  front_priority_o,
  output logic [CountW-1:0] count_o,
  output logic              empty_res_o,
  output logic              rejected_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [PrioW-1:0] prio_q [DEPTH];
  logic [PrioW-1:0] prio_d [DEPTH];
  logic [ElemW-1:0] elem_q [DEPTH];
  logic [ElemW-1:0] elem_d [DEPTH];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DEPTH-1:0] stay;
  logic [PrioW-1:0] front_prio_d, front_prio_q;
  logic [ElemW-1:0] front_elem_d, front_elem_q;
  logic             rej_q;

  always_comb begin
    // a cell stays put when it is live and not above the new priority
    for (int i = 0; i < DEPTH; i++) begin
      stay[i] = (CntW'(i) < cnt_q) && (prio_q[i] <= prio_i);
    end

    cnt_d        = cnt_q;
    prio_d       = prio_q;
    elem_d       = elem_q;
    front_prio_d = prio_q[0];
    front_elem_d = elem_q[0];

    case (cmd_i.op)
      OP_ENQ: begin
        cnt_d = cnt_q + 1'b1;
        if (!stay[0]) begin
          prio_d[0]    = prio_i;
          elem_d[0]    = elem_i;
          front_prio_d = prio_i;
          front_elem_d = elem_i;
        end
        for (int i = 1; i < DEPTH; i++) begin
          if (!stay[i]) begin
            if (stay[i-1]) begin
              prio_d[i] = prio_i;
              elem_d[i] = elem_i;
            end else begin
              prio_d[i] = prio_q[i-1];
              elem_d[i] = elem_q[i-1];
            end
          end
        end
      end
      OP_DEQ: begin
        if (cnt_q != '0) begin
          cnt_d        = cnt_q - 1'b1;
          front_prio_d = prio_q[1];
          front_elem_d = elem_q[1];
          for (int i = 0; i < DEPTH - 1; i++) begin
            prio_d[i] = prio_q[i+1];
            elem_d[i] = elem_q[i+1];
          end
        end
      end
      default: ;
    endcase

    // report zeros on an empty queue
    if (cnt_d == '0) begin
      front_prio_d = '0;
      front_elem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rej_q <= 1'b0;
    end else if (cmd_i.load) begin
      cnt_q <= cnt_d;
      rej_q <= cmd_i.reject;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prio_q       <= prio_d;
      elem_q       <= elem_d;
      front_prio_q <= front_prio_d;
      front_elem_q <= front_elem_d;
    end
  end

  assign status_o.full    = (cnt_q == CntW'(DEPTH));
  assign front_elem_o     = front_elem_q;
  assign front_priority_o = front_prio_q;
  assign count_o          = CountW'(cnt_q);
  assign empty_res_o      = (cnt_q == '0);
  assign rejected_o       = rej_q;

  `ASSERT_NEVER(a_cnt_in_range, clk_i, rst_ni, cnt_q > CntW'(DEPTH))
  `ASSERT_CLK(a_rej_only_full, clk_i, rst_ni, rej_q |-> status_o.full)
  for (genvar g = 0; g < DEPTH - 1; g++) begin : g_sorted
    `ASSERT_CLK(a_sorted, clk_i, rst_ni, (CntW'(g + 1) < cnt_q) |-> (prio_q[g] <= prio_q[g+1]))
  end

endmodule

[sv/ssq_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssq_ctrl
// Handshake controller: decodes the opcode and tracks the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssq_ctrl import ssq_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [OpW-1:0] op_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  ssq_status_t    status_i,
  output ssq_cmd_t       cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_e;

  state_e state_q, state_d;

  // stall only when a result is held and the sink is not taking it
  assign in_stall_o = (state_q == S_HOLD) && out_stall_i;

  always_comb begin
    cmd_o.load   = in_valid_i && !in_stall_o;
    cmd_o.op     = OP_STAT;
    cmd_o.reject = 1'b0;
    case (op_i)
      OP_ENQ: begin
        if (status_i.full) begin
          cmd_o.reject = 1'b1;
        end else begin
          cmd_o.op = OP_ENQ;
        end
      end
      OP_DEQ:  cmd_o.op = OP_DEQ;
      default: cmd_o.op = OP_STAT;
    endcase

    state_d = state_q;
    case (state_q)
      S_IDLE: if (cmd_o.load) state_d = S_HOLD;
      S_HOLD: if (!out_stall_i && !cmd_o.load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_o <= (state_d == S_HOLD);
    end
  end

  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, out_valid_o && out_stall_i && cmd_o.load)
  `ASSERT_CLK(a_load_gives_beat, clk_i, rst_ni, cmd_o.load |=> out_valid_o)
  `ASSERT_CLK(a_stall_needs_beat, clk_i, rst_ni, in_stall_o |-> out_valid_o)

endmodule
